// ===== rtl/core/mf3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int PIX_W         = 8;
  localparam int ROW_W         = 12;
  localparam int IMG_W_W       = 11;
  localparam int IMG_H_W       = 13;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int MED_TAPS      = 9;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [MED_TAPS-1:0] win_t;

  // per-pixel bookkeeping carried down the pipe
  typedef struct packed {
    logic             has_result;
    logic             frame_last;
    logic [ROW_W-1:0] row;
  } pix_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/median_filter_3x3_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 median filter, one 8-bit pixel per item in raster order.
// Throughput: 1 item per cycle unless a result waits on out_ready; the pipe is
// line-store read, window, median/out reg.
// Border pixels give no result; the last interior pixel carries out_frame_last.
// Reset (rst_n, synchronous): counters to row 0 / col 0, size back to 640 x 480,
// pipe empty. Line stores are not cleared; unwritten entries never reach a result.

module median_filter_3x3_unit
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // config
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_wdata,
  // pixel in
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [PIX_W-1:0]             in_pixel_value,
  // result out
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [PIX_W-1:0]             out_median_value,
  output logic      [ROW_W-1:0]             out_row,
  output logic      [$clog2(MAX_WIDTH)-1:0] out_col,
  output logic                              out_frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // position of the incoming pixel
  logic [COL_W-1:0] cur_col, cur_col_m1;
  pix_tag_t         cur_tag;
  logic             in_acc;

  // stage 1: line-store read in flight
  logic             s1_valid_r;
  pix_t             s1_px_r;
  logic [COL_W-1:0] s1_col_r, s1_col_m1_r;
  pix_tag_t         s1_tag_r;
  pix_t             rd_a, rd_b;   // row above, two rows above

  // stage 2: window holds the neighborhood
  logic             s2_valid_r;
  logic [COL_W-1:0] s2_col_m1_r;
  pix_tag_t         s2_tag_r;
  win_t             win_r, win_nxt;
  pix_t             med;

  // output register
  logic             out_valid_r;
  pix_t             out_med_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;

  logic out_en, s2_go, s2_free, s1_go, s1_free;

  // Hand-off chain: each stage moves on when the next one is empty or moving.
  // Items without a result leave stage 2 without touching the output register.
  assign out_en   = !out_valid_r || out_ready;
  assign s2_go    = s2_valid_r && (!s2_tag_r.has_result || out_en);
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_go;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && in_ready;

  mf3_coord #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (in_acc),
    .col       (cur_col),
    .col_m1    (cur_col_m1),
    .tag       (cur_tag)
  );

  // Both line stores read the current column on accept and are written back
  // when that item leaves stage 1: the newest row shifts from store a to b.
  // The same column comes round again only a full row later, so no hazard.
  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (cur_col),
    .rdata (rd_a)
  );

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (rd_a),
    .re    (in_acc),
    .raddr (cur_col),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r     <= in_pixel_value;
      s1_col_r    <= cur_col;
      s1_col_m1_r <= cur_col_m1;
      s1_tag_r    <= cur_tag;
    end
  end

  // window slides left, newest column enters at the right
  // taps 0..2: two rows above, 3..5: row above, 6..8: current row
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = rd_b;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = rd_a;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r       <= win_nxt;
      s2_col_m1_r <= s1_col_m1_r;
      s2_tag_r    <= s1_tag_r;
    end
  end

  mf3_median u_median (
    .win (win_r),
    .med (med)
  );

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_med_r  <= med;
      out_row_r  <= s2_tag_r.row;
      out_col_r  <= s2_col_m1_r;
      out_last_r <= s2_tag_r.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_acc;
      end
      if (s2_free) begin
        s2_valid_r <= s1_go;
      end
      if (out_en) begin
        out_valid_r <= s2_valid_r && s2_tag_r.has_result;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_med_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_frame_last   = out_last_r;

`ifndef NO_ASSERTIONS
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_tag_r.has_result |=> s2_valid_r && s2_tag_r.has_result)
    else $error("result item lost between stage 1 and window");
  a_out_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_row_r != '0 && out_col_r != '0)
    else $error("result on a border position");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("waiting result dropped");
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_tag_r.has_result && out_valid_r && !out_ready |=>
    s2_valid_r && $stable(win_r))
    else $error("window changed under a stalled result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mf3_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mf3_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mf3_median
  import mf3_pkg::*;
(
  input  wire win_t win,
  output pix_t      med
);

  // compare-exchange: afterwards v[a] <= v[b]
  function automatic win_t cx(input win_t v, input int a, input int b);
    win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  win_t p;

  // 19-exchange selection network, median lands in tap 4
  always_comb begin
    p = win;
    p = cx(p, 1, 2); p = cx(p, 4, 5); p = cx(p, 7, 8);
    p = cx(p, 0, 1); p = cx(p, 3, 4); p = cx(p, 6, 7);
    p = cx(p, 1, 2); p = cx(p, 4, 5); p = cx(p, 7, 8);
    p = cx(p, 0, 3); p = cx(p, 5, 8); p = cx(p, 4, 7);
    p = cx(p, 3, 6); p = cx(p, 1, 4); p = cx(p, 2, 5);
    p = cx(p, 4, 7); p = cx(p, 4, 2); p = cx(p, 6, 4);
    p = cx(p, 4, 2);
    med = p[4];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mf3_coord.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mf3_coord
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_wdata,
  input  wire logic                         adv,
  output logic      [$clog2(MAX_WIDTH)-1:0] col,
  output logic      [$clog2(MAX_WIDTH)-1:0] col_m1,
  output pix_tag_t                          tag
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [COL_W-1:0]   col_r, col_nxt, last_col_r, last_col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt, last_row_r, last_row_nxt;
  logic [IMG_W_W-1:0] wval;
  logic [IMG_H_W-1:0] hval;
  logic               cfg_hit;

  // clamp written sizes into range, keep them as last index
  always_comb begin
    wval = cfg_wdata[IMG_W_W-1:0];
    hval = cfg_wdata[IMG_H_W-1:0];
    if (wval < IMG_W_W'(3)) begin
      last_col_nxt = COL_W'(2);
    end else if (32'(wval) > MAX_WIDTH) begin
      last_col_nxt = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_nxt = COL_W'(wval - 1'b1);
    end
    if (hval < IMG_H_W'(3)) begin
      last_row_nxt = ROW_W'(2);
    end else if (32'(hval) > MAX_HEIGHT) begin
      last_row_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row_nxt = ROW_W'(hval - 1'b1);
    end
  end

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (adv) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      last_col_r <= COL_W'(RST_W - 1);
      last_row_r <= ROW_W'(RESET_HEIGHT - 1);
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
        last_col_r <= last_col_nxt;
      end
      if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
        last_row_r <= last_row_nxt;
      end
    end
  end

  assign col            = col_r;
  assign col_m1         = col_r - 1'b1;
  assign tag.has_result = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign tag.frame_last = (row_r == last_row_r) && (col_r == last_col_r);
  assign tag.row        = row_r - 1'b1;

`ifndef NO_ASSERTIONS
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col_r)
    else $error("column counter past end of row");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= last_row_r)
    else $error("row counter past end of frame");
`endif

endmodule

`default_nettype wire
